@@ hw/rtl/pulse_channel_with_sweep_unit_defines.svh @@
// Assertion macros for the pulse channel with sweep.
`ifndef PULSE_CHANNEL_WITH_SWEEP_UNIT_DEFINES_SVH
`define PULSE_CHANNEL_WITH_SWEEP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PCS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`define PCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PCS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define PCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/pcs_pkg.sv @@
package pcs_pkg;

	localparam int CMD_W = 2;
	localparam int IDX_W = 3;
	localparam int VAL_W = 8;
	localparam int AMP_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_WRITE = 2'd2
	} pcs_cmd_t;

	localparam logic [IDX_W-1:0] REG_SWEEP = 3'd0;
	localparam logic [IDX_W-1:0] REG_DUTY  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ENV   = 3'd2;
	localparam logic [IDX_W-1:0] REG_FLO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_FHI   = 3'd4;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             channel_active;
		logic             dac_enabled;
	} pcs_result_t;

	function automatic logic [7:0] duty_mask(input logic [1:0] sel);
		logic [7:0] m;
		case (sel)
			2'd0: m = 8'h80;
			2'd1: m = 8'hC0;
			2'd2: m = 8'hF0;
			default: m = 8'h3F;
		endcase
		return m;
	endfunction

	function automatic logic [13:0] reload_period(input logic [10:0] freq);
		logic [11:0] d;
		d = 12'd2048 - {1'b0, freq};
		return {d, 2'b00};
	endfunction

	// bit 11 of the result marks overflow past the 11-bit frequency range
	function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
			input logic [7:0] sweep_reg);
		logic [10:0] delta;
		logic [11:0] nxt;
		delta = shadow >> sweep_reg[2:0];
		if (sweep_reg[3]) begin
			nxt = {1'b0, shadow} - {1'b0, delta};
		end else begin
			nxt = {1'b0, shadow} + {1'b0, delta};
		end
		return nxt;
	endfunction

endpackage

@@ hw/rtl/pcs_core.sv @@
module pcs_core import pcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] reg_index,
	input  logic [VAL_W-1:0] reg_value,
	output pcs_result_t      result
);

	logic [4:0][7:0] reg_q, n_reg;
	logic [13:0]     period_q, n_period;
	logic [2:0]      duty_q, n_duty;
	logic [6:0]      len_q, n_len;
	logic [2:0]      env_cnt_q, n_env_cnt;
	logic [3:0]      vol_q, n_vol;
	logic            env_up_q, n_env_up;
	logic [2:0]      env_pace_q, n_env_pace;
	logic [10:0]     shadow_q, n_shadow;
	logic [3:0]      swcnt_q, n_swcnt;
	logic            sweep_on_q, n_sweep_on;
	logic            neg_q, n_neg;
	logic            active_q, n_active;
	logic [2:0]      pos_q, n_pos;
	logic [11:0]     calc1, calc2;
	logic [2:0]      pace, shift;
	logic            n_dac;
	logic [7:0]      mask;

	assign pace  = reg_q[0][6:4];
	assign shift = reg_q[0][2:0];

	always_comb begin
		n_reg      = reg_q;
		n_period   = period_q;
		n_duty     = duty_q;
		n_len      = len_q;
		n_env_cnt  = env_cnt_q;
		n_vol      = vol_q;
		n_env_up   = env_up_q;
		n_env_pace = env_pace_q;
		n_shadow   = shadow_q;
		n_swcnt    = swcnt_q;
		n_sweep_on = sweep_on_q;
		n_neg      = neg_q;
		n_active   = active_q;
		n_pos      = pos_q;
		calc1      = '0;
		calc2      = '0;
		case (cmd)
			CMD_TICK: begin
				if (n_active && (n_reg[2][7:3] != 5'd0)) begin
					n_period = n_period - 14'd1;
					if (n_period == 14'd0) begin
						n_period = reload_period({n_reg[4][2:0], n_reg[3]});
						n_duty   = n_duty + 3'd1;
					end
				end
			end
			CMD_STEP: begin
				if (!pos_q[0] && n_reg[4][6] && (n_len != 7'd0)) begin
					n_len = n_len - 7'd1;
					if (n_len == 7'd0) begin
						n_active = 1'b0;
					end
				end
				if ((pos_q == 3'd7) && n_active && (n_reg[2][7:3] != 5'd0)
						&& (n_env_pace != 3'd0)) begin
					if (n_env_cnt != 3'd0) begin
						n_env_cnt = n_env_cnt - 3'd1;
					end
					if (n_env_cnt == 3'd0) begin
						n_env_cnt = n_env_pace;
						if (n_env_up) begin
							if (n_vol != 4'hF) begin
								n_vol = n_vol + 4'd1;
							end
						end else if (n_vol != 4'd0) begin
							n_vol = n_vol - 4'd1;
						end
					end
				end
				if ((pos_q == 3'd2) || (pos_q == 3'd6)) begin
					if (n_swcnt != 4'd0) begin
						n_swcnt = n_swcnt - 4'd1;
					end
					if (n_swcnt == 4'd0) begin
						n_swcnt = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
						if (n_sweep_on && (pace != 3'd0)) begin
							calc1 = sweep_calc(n_shadow, reg_q[0]);
							if (reg_q[0][3]) begin
								n_neg = 1'b1;
							end
							if (calc1[11]) begin
								n_active = 1'b0;
							end
							if (!calc1[11] && (shift != 3'd0)) begin
								n_reg[3] = calc1[7:0];
								n_reg[4] = {n_reg[4][7:3], calc1[10:8]};
								n_shadow = calc1[10:0];
								calc2    = sweep_calc(n_shadow, reg_q[0]);
								if (calc2[11]) begin
									n_active = 1'b0;
								end
							end
						end
					end
				end
				n_pos = pos_q + 3'd1;
			end
			CMD_WRITE: begin
				case (reg_index)
					REG_SWEEP: begin
						if (reg_q[0][3] && !reg_value[3] && n_neg) begin
							n_neg    = 1'b0;
							n_active = 1'b0;
						end
						n_reg[0] = reg_value;
					end
					REG_DUTY: begin
						n_reg[1] = reg_value;
						n_len    = 7'd64 - {1'b0, reg_value[5:0]};
					end
					REG_ENV: begin
						if (reg_value[7:3] == 5'd0) begin
							n_active = 1'b0;
						end
						if (reg_value[3]) begin
							n_vol = n_vol + 4'd1;
						end
						n_reg[2] = reg_value;
					end
					REG_FLO: begin
						n_reg[3] = reg_value;
					end
					REG_FHI: begin
						n_reg[4] = reg_value;
						if (pos_q[0] && reg_value[6] && !reg_q[4][6] && (n_len != 7'd0)) begin
							n_len = n_len - 7'd1;
							if (n_len == 7'd0) begin
								n_active = 1'b0;
							end
						end
						if (reg_value[7]) begin
							n_neg = 1'b0;
							if (n_len == 7'd0) begin
								n_len = (pos_q[0] && reg_value[6]) ? 7'd63 : 7'd64;
							end
							n_period   = reload_period({reg_value[2:0], n_reg[3]});
							n_vol      = n_reg[2][7:4];
							n_env_up   = n_reg[2][3];
							n_env_pace = n_reg[2][2:0];
							n_env_cnt  = n_reg[2][2:0];
							n_active   = (n_reg[2][7:3] != 5'd0);
							n_shadow   = {reg_value[2:0], n_reg[3]};
							n_swcnt    = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
							n_sweep_on = (pace != 3'd0) || (shift != 3'd0);
							if (shift != 3'd0) begin
								calc1 = sweep_calc(n_shadow, reg_q[0]);
								if (reg_q[0][3]) begin
									n_neg = 1'b1;
								end
								if (calc1[11]) begin
									n_active = 1'b0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign n_dac = (n_reg[2][7:3] != 5'd0);
	assign mask  = duty_mask(n_reg[1][7:6]);

	always_comb begin
		result.channel_active = n_active;
		result.dac_enabled    = n_dac;
		result.amplitude      = (n_active && n_dac && mask[n_duty]) ? n_vol : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q      <= '0;
			period_q   <= '0;
			duty_q     <= '0;
			len_q      <= '0;
			env_cnt_q  <= '0;
			vol_q      <= '0;
			env_up_q   <= 1'b0;
			env_pace_q <= '0;
			shadow_q   <= '0;
			swcnt_q    <= '0;
			sweep_on_q <= 1'b0;
			neg_q      <= 1'b0;
			active_q   <= 1'b0;
			pos_q      <= '0;
		end else if (advance) begin
			reg_q      <= n_reg;
			period_q   <= n_period;
			duty_q     <= n_duty;
			len_q      <= n_len;
			env_cnt_q  <= n_env_cnt;
			vol_q      <= n_vol;
			env_up_q   <= n_env_up;
			env_pace_q <= n_env_pace;
			shadow_q   <= n_shadow;
			swcnt_q    <= n_swcnt;
			sweep_on_q <= n_sweep_on;
			neg_q      <= n_neg;
			active_q   <= n_active;
			pos_q      <= n_pos;
		end
	end

endmodule

@@ hw/rtl/pulse_channel_with_sweep_unit.sv @@
// Square-wave sound channel with frequency sweep, volume envelope and length
// counter. Each input transaction is a clock tick, a frame-sequencer step or a
// register write; each yields exactly one result transaction with the current
// amplitude, the channel-on flag and the DAC-on flag after that update. One
// transaction is accepted every cycle while in_stall is low: the whole channel update
// is a single combinational pass between the input register and the result register,
// so throughput is one per clock unless out_stall holds the result. An accepted transaction
// is registered in the input register and then in the result register. in_stall rises only
// while the result register is held by out_stall and the input register is full.
`include "pulse_channel_with_sweep_unit_defines.svh"

module pulse_channel_with_sweep_unit import pcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0] reg_index,
	input  logic [VAL_W-1:0] reg_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [AMP_W-1:0] amplitude,
	output logic             channel_active,
	output logic             dac_enabled
);

	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [VAL_W-1:0] val_s1;
	logic             advance;
	pcs_result_t      result;
	pcs_result_t      result_q;
	logic             out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd;
			idx_s1 <= reg_index;
			val_s1 <= reg_value;
		end
	end

	pcs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cmd       (cmd_s1),
		.reg_index (idx_s1),
		.reg_value (val_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign amplitude      = result_q.amplitude;
	assign channel_active = result_q.channel_active;
	assign dac_enabled    = result_q.dac_enabled;

	`PCS_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, in_stall, valid_s1, "stall without held item")
	`PCS_ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q, "result not presented")
	`PCS_ASSERT_IMPLY(a_active_needs_dac, clk, arst_n, out_valid_q && channel_active, dac_enabled, "channel on with DAC off")
	`PCS_ASSERT_IMPLY(a_amp_needs_active, clk, arst_n, out_valid_q && (amplitude != '0), channel_active, "sound from an off channel")

endmodule

@@ bench/pulse_channel_with_sweep_unit_test.sv @@
module pulse_channel_with_sweep_unit_test import pcs_pkg::*; ();

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int IDX_TOP = (1 << IDX_W) - 1;
	localparam logic [11:0] FREQ_LIMIT = 12'd2047;
	localparam logic [31:0] DUTY_WAVES = {8'h3F, 8'hF0, 8'hC0, 8'h80};
	localparam int OP_TARGET = 580;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
	} apu_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = '0;
	logic [IDX_W-1:0] reg_index = '0;
	logic [VAL_W-1:0] reg_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [AMP_W-1:0] amplitude;
	logic channel_active;
	logic dac_enabled;

	apu_op_t cpu_ops[$];
	pcs_result_t pending_samples[$];
	int useful_ops = 0;
	int fails = 0;
	int cycle_count = 0;
	bit in_fired = 1'b0;
	bit out_fired = 1'b0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_hold = 0;

	logic [7:0] chan_regs [0:4] = '{default: 8'h00};
	logic [13:0] period_cnt = '0;
	logic [2:0] wave_step = '0;
	logic [6:0] len_cnt = '0;
	logic [2:0] env_cnt = '0;
	logic [3:0] vol = '0;
	logic env_rise = 1'b0;
	logic [2:0] env_reload = '0;
	logic [10:0] sweep_shadow = '0;
	logic [3:0] sweep_cnt = '0;
	logic sweep_en = 1'b0;
	logic neg_seen = 1'b0;
	logic chan_on = 1'b0;
	logic [2:0] seq_step = '0;

	pulse_channel_with_sweep_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.amplitude(amplitude),
		.channel_active(channel_active),
		.dac_enabled(dac_enabled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic dac_live();
		return chan_regs[2][7:3] != 5'd0;
	endfunction

	function automatic logic [10:0] freq_now();
		return {chan_regs[4][2:0], chan_regs[3]};
	endfunction

	function automatic logic [13:0] period_reload();
		logic [13:0] span;
		span = 14'd2048 - {3'b000, freq_now()};
		return span << 2;
	endfunction

	function automatic void length_tick();
		if (chan_regs[4][6]) begin
			if (len_cnt != 0) begin
				len_cnt = len_cnt - 1'b1;
				if (len_cnt == 0)
					chan_on = 1'b0;
			end
		end
	endfunction

	function automatic logic [11:0] sweep_next();
		logic [10:0] delta;
		logic [11:0] nxt;
		delta = sweep_shadow >> chan_regs[0][2:0];
		if (chan_regs[0][3]) begin
			neg_seen = 1'b1;
			nxt = {1'b0, sweep_shadow} - {1'b0, delta};
		end else begin
			nxt = {1'b0, sweep_shadow} + {1'b0, delta};
		end
		if (nxt > FREQ_LIMIT)
			chan_on = 1'b0;
		return nxt;
	endfunction

	function automatic void sweep_tick();
		logic [2:0] pace;
		logic [11:0] nxt;
		pace = chan_regs[0][6:4];
		if (sweep_cnt != 0)
			sweep_cnt = sweep_cnt - 1'b1;
		if (sweep_cnt == 0) begin
			sweep_cnt = (pace == 0) ? 4'd8 : {1'b0, pace};
			if (sweep_en && pace != 0) begin
				nxt = sweep_next();
				if (nxt <= FREQ_LIMIT && chan_regs[0][2:0] != 0) begin
					chan_regs[3] = nxt[7:0];
					chan_regs[4] = {chan_regs[4][7:3], nxt[10:8]};
					sweep_shadow = nxt[10:0];
					void'(sweep_next());
				end
			end
		end
	endfunction

	function automatic void envelope_tick();
		if (chan_on && dac_live() && env_reload != 0) begin
			if (env_cnt != 0)
				env_cnt = env_cnt - 1'b1;
			if (env_cnt == 0) begin
				env_cnt = env_reload;
				if (env_rise) begin
					if (vol != 4'hF)
						vol = vol + 1'b1;
				end else if (vol != 0) begin
					vol = vol - 1'b1;
				end
			end
		end
	endfunction

	function automatic void frame_step();
		if (!seq_step[0])
			length_tick();
		if (seq_step == 3'd7)
			envelope_tick();
		if (seq_step == 3'd2 || seq_step == 3'd6)
			sweep_tick();
		seq_step = seq_step + 1'b1;
	endfunction

	function automatic void retrigger();
		logic [2:0] pace;
		pace = chan_regs[0][6:4];
		neg_seen = 1'b0;
		if (len_cnt == 0) begin
			len_cnt = 7'd64;
			if (seq_step[0] && chan_regs[4][6])
				len_cnt = len_cnt - 1'b1;
		end
		period_cnt = period_reload();
		vol = chan_regs[2][7:4];
		env_rise = chan_regs[2][3];
		env_reload = chan_regs[2][2:0];
		env_cnt = env_reload;
		chan_on = dac_live();
		sweep_shadow = freq_now();
		sweep_cnt = (pace == 0) ? 4'd8 : {1'b0, pace};
		sweep_en = (pace != 0) || (chan_regs[0][2:0] != 0);
		if (chan_regs[0][2:0] != 0)
			void'(sweep_next());
	endfunction

	function automatic void reg_write(input logic [IDX_W-1:0] idx, input logic [7:0] val);
		logic [7:0] prev;
		case (idx)
			REG_SWEEP: begin
				if (chan_regs[0][3] && !val[3] && neg_seen) begin
					neg_seen = 1'b0;
					chan_on = 1'b0;
				end
				chan_regs[0] = val;
			end
			REG_DUTY: begin
				chan_regs[1] = val;
				len_cnt = 7'd64 - {1'b0, val[5:0]};
			end
			REG_ENV: begin
				if (val[7:3] == 0)
					chan_on = 1'b0;
				if (val[3])
					vol = vol + 1'b1;
				chan_regs[2] = val;
			end
			REG_FLO: begin
				chan_regs[3] = val;
			end
			REG_FHI: begin
				prev = chan_regs[4];
				chan_regs[4] = val;
				if (seq_step[0] && val[6] && !prev[6])
					length_tick();
				if (val[7])
					retrigger();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void period_tick();
		if (chan_on && dac_live()) begin
			period_cnt = period_cnt - 1'b1;
			if (period_cnt == 0) begin
				period_cnt = period_reload();
				wave_step = wave_step + 1'b1;
			end
		end
	endfunction

	function automatic pcs_result_t channel_update(input apu_op_t op);
		pcs_result_t res;
		case (op.cmd)
			CMD_TICK: period_tick();
			CMD_STEP: frame_step();
			CMD_WRITE: reg_write(op.idx, op.val);
			default: begin
			end
		endcase
		res.amplitude = '0;
		if (chan_on && dac_live() && DUTY_WAVES[{chan_regs[1][7:6], wave_step}])
			res.amplitude = vol;
		res.channel_active = chan_on;
		res.dac_enabled = dac_live();
		return res;
	endfunction

	function automatic int unsigned gap_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic add_op(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] i,
			input logic [VAL_W-1:0] v);
		apu_op_t op;
		op.cmd = c;
		op.idx = i;
		op.val = v;
		cpu_ops.push_back(op);
		if (c != CMD_NONE && !(c == CMD_WRITE && i > REG_FHI))
			useful_ops++;
	endtask

	task automatic add_voice();
		int unsigned n;
		int unsigned r;
		logic [2:0] hi;
		hi = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111;
		add_op(CMD_WRITE, REG_SWEEP, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
		add_op(CMD_WRITE, REG_DUTY, 8'($urandom));
		add_op(CMD_WRITE, REG_ENV,
			($urandom_range(0, 9) == 0) ? {5'b00000, 3'($urandom)} : 8'($urandom));
		add_op(CMD_WRITE, REG_FLO, 8'($urandom));
		add_op(CMD_WRITE, REG_FHI, {1'b1, 1'($urandom), 3'($urandom), hi});
		n = $urandom_range(12, 48);
		repeat (n) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				add_op(CMD_TICK, 3'($urandom), 8'($urandom));
			else if (r < 18)
				add_op(CMD_STEP, 3'($urandom), 8'($urandom));
			else if (r == 18)
				add_op(CMD_WRITE, ($urandom_range(0, 1) != 0) ? REG_ENV : REG_SWEEP,
					8'($urandom));
			else
				add_op(CMD_WRITE, ($urandom_range(0, 1) != 0) ? REG_FHI : REG_DUTY,
					8'($urandom));
		end
	endtask

	task automatic add_noise();
		int unsigned n;
		n = $urandom_range(3, 10);
		repeat (n)
			add_op(2'($urandom_range(0, 3)), 3'($urandom_range(0, IDX_TOP)), 8'($urandom));
	endtask

	always @(posedge clk) begin : watch
		pcs_result_t want;
		apu_op_t seen;
		in_fired = in_valid && !in_stall;
		out_fired = out_valid && !out_stall;
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL pulse_channel_with_sweep_unit");
			$finish;
		end else if (arst_n) begin
			if (out_fired) begin
				if (pending_samples.size() == 0) begin
					$error("unexpected transaction: amplitude=%0d channel_active=%0d dac_enabled=%0d",
						amplitude, channel_active, dac_enabled);
					fails++;
				end else begin
					want = pending_samples.pop_front();
					if (amplitude !== want.amplitude) begin
						$error("amplitude: expected %0d, got %0d", want.amplitude, amplitude);
						fails++;
					end
					if (channel_active !== want.channel_active) begin
						$error("channel_active: expected %0d, got %0d",
							want.channel_active, channel_active);
						fails++;
					end
					if (dac_enabled !== want.dac_enabled) begin
						$error("dac_enabled: expected %0d, got %0d",
							want.dac_enabled, dac_enabled);
						fails++;
					end
				end
			end
			if (in_fired) begin
				seen.cmd = cmd;
				seen.idx = reg_index;
				seen.val = reg_value;
				pending_samples.push_back(channel_update(seen));
			end
		end
	end

	always @(negedge clk) begin : feed
		apu_op_t op;
		logic busy;
		if (arst_n) begin
			busy = in_valid && !in_fired;
			if (!busy) begin
				if (in_gap != 0) begin
					in_gap = in_gap - 1;
				end else if (cpu_ops.size() != 0) begin
					op = cpu_ops.pop_front();
					cmd <= op.cmd;
					reg_index <= op.idx;
					reg_value <= op.val;
					busy = 1'b1;
					if ($urandom_range(0, 29) == 0)
						in_calm = !in_calm;
					in_gap = gap_draw(in_calm);
				end
			end
			in_valid <= busy;
		end
	end

	always @(negedge clk) begin : drain
		if (out_fired) begin
			if ($urandom_range(0, 29) == 0)
				out_calm = !out_calm;
			out_hold = gap_draw(out_calm);
		end
		out_stall <= (out_hold != 0);
		if (out_hold != 0)
			out_hold = out_hold - 1;
	end

	initial begin
		add_op(CMD_NONE, REG_SWEEP, 8'hFF);
		add_op(CMD_WRITE, 3'(IDX_TOP), 8'hFF);
		add_op(CMD_WRITE, REG_FHI + 1'b1, 8'h00);
		add_op(CMD_WRITE, REG_ENV, 8'hF0);
		add_op(CMD_WRITE, REG_DUTY, 8'hBF);
		add_op(CMD_WRITE, REG_FLO, 8'hFF);
		add_op(CMD_WRITE, REG_FHI, 8'hC7);
		repeat (4)
			add_op(CMD_TICK, REG_SWEEP, 8'h00);
		add_op(CMD_STEP, REG_SWEEP, 8'h00);
		add_op(CMD_WRITE, REG_ENV, 8'h08);
		add_op(CMD_WRITE, REG_ENV, 8'hA9);
		add_op(CMD_WRITE, REG_SWEEP, 8'h79);
		add_op(CMD_WRITE, REG_FHI, 8'h87);
		add_op(CMD_WRITE, REG_SWEEP, 8'h71);
		add_op(CMD_WRITE, REG_SWEEP, 8'h11);
		add_op(CMD_WRITE, REG_FHI, 8'h87);
		add_op(CMD_WRITE, REG_SWEEP, 8'h00);
		add_op(CMD_WRITE, REG_FLO, 8'h00);
		add_op(CMD_WRITE, REG_FHI, 8'h80);
		add_op(CMD_WRITE, REG_DUTY, 8'h00);
		repeat (2)
			add_op(CMD_STEP, REG_SWEEP, 8'h00);
		while (useful_ops < OP_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			else
				add_voice();
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cpu_ops.size() != 0 || in_valid || pending_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && pending_samples.size() == 0)
			$display("PASS pulse_channel_with_sweep_unit");
		else
			$display("FAIL pulse_channel_with_sweep_unit");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_core.sv
hw/rtl/pulse_channel_with_sweep_unit.sv
bench/pulse_channel_with_sweep_unit_test.sv
